// File: rtl/core/bbsurf_pkg.sv
// ----------------------------------------------------------------------------
// bbsurf_pkg
// shared constants and helpers for the bicubic bezier surface evaluator
// ----------------------------------------------------------------------------
package bbsurf_pkg;

    localparam int POINTS_PER_PATCH = 16;
    localparam int NUM_PATCHES      = 2;
    localparam int STORE_DEPTH      = NUM_PATCHES * POINTS_PER_PATCH;
    localparam int IDX_W            = $clog2(STORE_DEPTH);
    localparam int PT_IDX_W         = $clog2(POINTS_PER_PATCH);
    localparam int DEF_COORD_WIDTH  = 32;
    localparam int NUM_AXES         = 3;
    localparam int ROWS             = 4;
    localparam int COLS             = 4;
    localparam int VAL_W            = 32;
    localparam int CRD_W            = 17;
    localparam int W_W              = 31;
    localparam int B_W              = 51;
    localparam int ACC_W            = 66;

    localparam logic [CRD_W-1:0] ONE_Q16  = 17'd65536;
    localparam logic [CRD_W-1:0] HALF_Q16 = 17'd32768;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    // bernstein product rounded from q0.48 to q0.30
    function automatic logic [W_W-1:0] f_round_w(input logic [B_W-1:0] b);
        logic [B_W-1:0] r;
        begin
            r = b + (B_W'(1) << 17);
            return r[18 +: W_W];
        end
    endfunction

    // clamp a coordinate to one
    function automatic logic [CRD_W-1:0] f_clamp(input logic [CRD_W-1:0] c);
        begin
            return (c > ONE_Q16) ? ONE_Q16 : c;
        end
    endfunction

endpackage

// File: rtl/core/bicubic_bezier_surface_evaluator_top.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_surface_evaluator_top
// two-patch bicubic bezier surface evaluator, q16.16, seven-stage pipeline
// ----------------------------------------------------------------------------
//  channel | valid    | stall    | payload
//  input   | i_valid  | o_stall  | action, patch, index, point xyz, u, v
//  output  | o_valid  | i_stall  | surface xyz
//
//  one item per cycle while o_stall is low; an evaluate transfer's result is registered through stages 1 to 7
//  the depth is set by the store read, the weight multipliers (2 stages), and two multiply and blend levels
//  loads write the control point store at their transfer and give no result
//  i_rst_n clears all pipeline valid bits; the store is undefined until written
//  a held result freezes the whole pipeline, so o_stall follows i_stall while o_valid is high
module bicubic_bezier_surface_evaluator_top
    import bbsurf_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_action,
    input  logic                     i_patch_select,
    input  logic [PT_IDX_W-1:0]      i_point_index,
    input  logic signed [VAL_W-1:0]  i_point_x,
    input  logic signed [VAL_W-1:0]  i_point_y,
    input  logic signed [VAL_W-1:0]  i_point_z,
    input  logic [CRD_W-1:0]         i_coord_u,
    input  logic [CRD_W-1:0]         i_coord_v,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [VAL_W-1:0]  o_surface_x,
    output logic signed [VAL_W-1:0]  o_surface_y,
    output logic signed [VAL_W-1:0]  o_surface_z
);

    localparam int SAT_BITS = (COORD_WIDTH < VAL_W) ? COORD_WIDTH : VAL_W;
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAT_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< 29;

    function automatic logic signed [VAL_W-1:0] f_rnd_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] q;
        begin
            q = (a + RND) >>> 30;
            if (q > SAT_HI) begin
                q = SAT_HI;
            end else if (q < SAT_LO) begin
                q = SAT_LO;
            end
            return q[VAL_W-1:0];
        end
    endfunction

    logic adv;
    logic acc_in;

    // control point store
    logic signed [VAL_W-1:0] r_store [NUM_AXES][STORE_DEPTH];

    // pipeline valid bits, stage 7 is the output
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    logic [CRD_W-1:0] n_t, u_c;
    logic u_hi;
    logic [CRD_W-1:0] r_t1, r_v_1;
    logic [CRD_W-1:0] r_st2, r_tt2, r_sv2, r_tv2;
    logic [2*CRD_W-1:0] r_ss2, r_ts2, r_t22, r_vss2, r_vts2, r_vt22;
    logic [W_W-1:0] r_wu3 [COLS];
    logic [W_W-1:0] r_wv3 [ROWS];
    logic [W_W-1:0] r_wv4 [ROWS];
    logic [W_W-1:0] r_wv5 [ROWS];
    logic signed [VAL_W-1:0] r_p1 [NUM_AXES][POINTS_PER_PATCH];
    logic signed [VAL_W-1:0] r_p2 [NUM_AXES][POINTS_PER_PATCH];
    logic signed [VAL_W-1:0] r_p3 [NUM_AXES][POINTS_PER_PATCH];
    logic signed [2*VAL_W-1:0] r_pr4 [NUM_AXES][POINTS_PER_PATCH];
    logic signed [VAL_W-1:0] r_row5 [NUM_AXES][ROWS];
    logic signed [2*VAL_W-1:0] r_pv6 [NUM_AXES][ROWS];
    logic signed [VAL_W-1:0] r_out7 [NUM_AXES];

    assign adv     = !(r_v7 && i_stall);
    assign o_stall = !adv;
    assign acc_in  = i_valid && adv;

    always_comb begin
        u_c  = f_clamp(i_coord_u);
        u_hi = (u_c >= HALF_Q16);
        if (!u_hi) begin
            n_t = CRD_W'(u_c << 1);
        end else begin
            n_t = CRD_W'((u_c - HALF_Q16) << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in && i_action == ACT_LOAD) begin
            r_store[0][{i_patch_select, i_point_index}] <= i_point_x;
            r_store[1][{i_patch_select, i_point_index}] <= i_point_y;
            r_store[2][{i_patch_select, i_point_index}] <= i_point_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid && i_action == ACT_EVAL;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1: coordinates and the patch chosen by the u half
            r_t1  <= n_t;
            r_v_1 <= f_clamp(i_coord_v);
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < POINTS_PER_PATCH; k++) begin
                    r_p1[a][k] <= r_store[a][{u_hi, PT_IDX_W'(k)}];
                end
            end
            // stage 2: squares and cross terms
            r_st2  <= ONE_Q16 - r_t1;
            r_tt2  <= r_t1;
            r_sv2  <= ONE_Q16 - r_v_1;
            r_tv2  <= r_v_1;
            r_ss2  <= (ONE_Q16 - r_t1) * (ONE_Q16 - r_t1);
            r_ts2  <= r_t1 * (ONE_Q16 - r_t1);
            r_t22  <= r_t1 * r_t1;
            r_vss2 <= (ONE_Q16 - r_v_1) * (ONE_Q16 - r_v_1);
            r_vts2 <= r_v_1 * (ONE_Q16 - r_v_1);
            r_vt22 <= r_v_1 * r_v_1;
            r_p2   <= r_p1;
            // stage 3: rounded weights
            r_wu3[0] <= f_round_w(B_W'(r_ss2) * r_st2);
            r_wu3[1] <= f_round_w(B_W'(r_ts2) * r_st2 * 2'd3);
            r_wu3[2] <= f_round_w(B_W'(r_ts2) * r_tt2 * 2'd3);
            r_wu3[3] <= f_round_w(B_W'(r_t22) * r_tt2);
            r_wv3[0] <= f_round_w(B_W'(r_vss2) * r_sv2);
            r_wv3[1] <= f_round_w(B_W'(r_vts2) * r_sv2 * 2'd3);
            r_wv3[2] <= f_round_w(B_W'(r_vts2) * r_tv2 * 2'd3);
            r_wv3[3] <= f_round_w(B_W'(r_vt22) * r_tv2);
            r_p3     <= r_p2;
            // stage 4: point times u weight
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int k = 0; k < POINTS_PER_PATCH; k++) begin
                    r_pr4[a][k] <= r_p3[a][k] * $signed({1'b0, r_wu3[k % COLS]});
                end
            end
            r_wv4 <= r_wv3;
            // stage 5: row blends
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int r = 0; r < ROWS; r++) begin
                    r_row5[a][r] <= f_rnd_sat(ACC_W'(r_pr4[a][r*COLS])
                                            + ACC_W'(r_pr4[a][r*COLS+1])
                                            + ACC_W'(r_pr4[a][r*COLS+2])
                                            + ACC_W'(r_pr4[a][r*COLS+3]));
                end
            end
            r_wv5 <= r_wv4;
            // stage 6: row times v weight
            for (int a = 0; a < NUM_AXES; a++) begin
                for (int r = 0; r < ROWS; r++) begin
                    r_pv6[a][r] <= r_row5[a][r] * $signed({1'b0, r_wv5[r]});
                end
            end
            // stage 7: final blend
            for (int a = 0; a < NUM_AXES; a++) begin
                r_out7[a] <= f_rnd_sat(ACC_W'(r_pv6[a][0]) + ACC_W'(r_pv6[a][1])
                                     + ACC_W'(r_pv6[a][2]) + ACC_W'(r_pv6[a][3]));
            end
        end
    end

    assign o_valid     = r_v7;
    assign o_surface_x = r_out7[0];
    assign o_surface_y = r_out7[1];
    assign o_surface_z = r_out7[2];

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall without a held result");

    a_last_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v6 && !o_stall) |=> o_valid)
        else $error("result lost at the output stage");

    a_no_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_action == ACT_LOAD) |=> !r_v1)
        else $error("load entered the evaluation pipeline");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// File: bench/bicubic_bezier_surface_evaluator_top_tb.sv
// ----------------------------------------------------------------------------
// bicubic_bezier_surface_evaluator_top_tb
// self-checking bench: control point loads and surface evaluations are
// driven over the valid/stall input channel, every evaluate transfer is
// predicted in q16.16 by a local bernstein blend with saturation, and each
// output transfer is compared field by field against the oldest prediction
// ----------------------------------------------------------------------------
module bicubic_bezier_surface_evaluator_top_tb;
    import bbsurf_pkg::*;

    typedef struct {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
    } t_position;

    typedef longint t_quad [4];

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_action;
    logic                    i_patch_select;
    logic [PT_IDX_W-1:0]     i_point_index;
    logic signed [VAL_W-1:0] i_point_x;
    logic signed [VAL_W-1:0] i_point_y;
    logic signed [VAL_W-1:0] i_point_z;
    logic [CRD_W-1:0]        i_coord_u;
    logic [CRD_W-1:0]        i_coord_v;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [VAL_W-1:0] o_surface_x;
    logic signed [VAL_W-1:0] o_surface_y;
    logic signed [VAL_W-1:0] o_surface_z;

    logic signed [VAL_W-1:0] ctl_x [STORE_DEPTH];
    logic signed [VAL_W-1:0] ctl_y [STORE_DEPTH];
    logic signed [VAL_W-1:0] ctl_z [STORE_DEPTH];
    t_position pending_positions [$];
    int  mismatches = 0;
    int  hold_request = 0;
    bit  quiet = 0;
    bit  send_idle = 1;

    bicubic_bezier_surface_evaluator_top uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("bicubic_bezier_surface_evaluator_top test failed");
        $finish;
    end

    function automatic t_quad bern_weights(input logic [CRD_W-1:0] t);
        longint unsigned tt, s, b [4];
        t_quad w;
        tt = t;
        s = 65536 - tt;
        b[0] = s * s * s;
        b[1] = 3 * tt * s * s;
        b[2] = 3 * tt * tt * s;
        b[3] = tt * tt * tt;
        for (int k = 0; k < 4; k++) w[k] = longint'((b[k] + (64'd1 << 17)) >> 18);
        return w;
    endfunction

    function automatic longint blend_sat(input t_quad p, input t_quad w);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++) acc += p[k] * w[k];
        acc = (acc + (64'sd1 <<< 29)) >>> 30;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc;
    endfunction

    function automatic longint surface_axis(input logic signed [VAL_W-1:0] pts [STORE_DEPTH],
                                            input int base, input t_quad wu, input t_quad wv);
        t_quad rows, p;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) p[c] = pts[IDX_W'(base + r * 4 + c)];
            rows[r] = blend_sat(p, wu);
        end
        return blend_sat(rows, wv);
    endfunction

    function automatic t_position surface_position(input logic [CRD_W-1:0] u_in,
                                                   input logic [CRD_W-1:0] v_in);
        logic [CRD_W-1:0] u, v, t;
        int base;
        t_quad wu, wv;
        t_position pos;
        u = (u_in > ONE_Q16) ? ONE_Q16 : u_in;
        v = (v_in > ONE_Q16) ? ONE_Q16 : v_in;
        if (u < HALF_Q16) begin
            t = CRD_W'(u << 1);
            base = 0;
        end else begin
            t = CRD_W'((u - HALF_Q16) << 1);
            base = POINTS_PER_PATCH;
        end
        wu = bern_weights(t);
        wv = bern_weights(v);
        pos.x = VAL_W'(surface_axis(ctl_x, base, wu, wv));
        pos.y = VAL_W'(surface_axis(ctl_y, base, wu, wv));
        pos.z = VAL_W'(surface_axis(ctl_z, base, wu, wv));
        return pos;
    endfunction

    task automatic send_item(input t_action act, input logic patch, input logic [3:0] idx,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz,
                             input logic [CRD_W-1:0] u, input logic [CRD_W-1:0] v);
        bit ready;
        int gap;
        if (send_idle && !quiet && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 18);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_patch_select <= patch;
        i_point_index  <= idx;
        i_point_x      <= px;
        i_point_y      <= py;
        i_point_z      <= pz;
        i_coord_u      <= u;
        i_coord_v      <= v;
        do begin
            @(negedge i_clk);
            ready = !o_stall;
            @(posedge i_clk);
        end while (!ready);
        if (act == ACT_LOAD) begin
            ctl_x[{patch, idx}] = px;
            ctl_y[{patch, idx}] = py;
            ctl_z[{patch, idx}] = pz;
        end else begin
            pending_positions.push_back(surface_position(u, v));
        end
    endtask

    task automatic load_point(input int entry, input logic [31:0] px,
                              input logic [31:0] py, input logic [31:0] pz);
        send_item(ACT_LOAD, 1'(entry / POINTS_PER_PATCH),
                  PT_IDX_W'(entry % POINTS_PER_PATCH),
                  px, py, pz, CRD_W'($urandom), CRD_W'($urandom));
    endtask

    task automatic evaluate_at(input logic [CRD_W-1:0] u, input logic [CRD_W-1:0] v);
        send_item(ACT_EVAL, 1'($urandom), PT_IDX_W'($urandom),
                  $urandom, $urandom, $urandom, u, v);
    endtask

    function automatic logic [CRD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0: return CRD_W'($urandom);
            1: return CRD_W'($urandom_range(0, 3));
            2: return CRD_W'($urandom_range(65533, 65536));
            3: return CRD_W'($urandom_range(32766, 32770));
            default: return CRD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
            default: return $urandom;
        endcase
    endfunction

    // all points at full scale so blends land on the saturation limits
    task automatic test_extremes();
        for (int e = 0; e < STORE_DEPTH; e++)
            load_point(e, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        evaluate_at(17'd0, 17'd0);
        evaluate_at(17'd16384, 17'd40000);
        evaluate_at(17'd32768, 17'd65536);
        evaluate_at(17'h1ffff, 17'h1ffff);
        for (int e = 0; e < STORE_DEPTH; e++)
            load_point(e, 32'h80000000, 32'h7fffffff, 32'h00000000);
        evaluate_at(17'd32767, 17'd32768);
        evaluate_at(17'd65535, 17'd1);
    endtask

    // random points; corner, seam, clamped and interior coordinates
    task automatic test_corners();
        for (int e = 0; e < STORE_DEPTH; e++)
            load_point(e, random_value(), random_value(), random_value());
        evaluate_at(17'd0, 17'd65536);
        evaluate_at(17'd32767, 17'd0);
        evaluate_at(17'd32768, 17'd0);
        evaluate_at(17'd32769, 17'd65535);
        evaluate_at(17'd65536, 17'd65536);
        evaluate_at(17'd70000, 17'd100000);
        evaluate_at(17'd1, 17'd1);
        evaluate_at(17'd49152, 17'd16384);
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 3) == 0)
                load_point($urandom_range(0, STORE_DEPTH - 1),
                           random_value(), random_value(), random_value());
            else
                evaluate_at(random_coord(), random_coord());
        end
    endtask

    // receiver holds off while the sender keeps offering, then sender waits for drain
    task automatic test_backpressure();
        hold_request = 300;
        test_random(60);
        send_idle = 0;
        test_random(40);
        send_idle = 1;
        i_valid <= 1'b0;
        wait (pending_positions.size() == 0);
        @(posedge i_clk);
        test_random(30);
    endtask

    initial begin
        int burst_left, hold_left;
        burst_left = 0;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 11) == 0) begin
                burst_left = $urandom_range(0, 17);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_position want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_positions.size() == 0) begin
                    $error("result transfer with no evaluation pending");
                    mismatches++;
                end else begin
                    want = pending_positions.pop_front();
                    if (o_surface_x !== want.x) begin
                        $error("surface_x expected %0d actual %0d", want.x, o_surface_x);
                        mismatches++;
                    end
                    if (o_surface_y !== want.y) begin
                        $error("surface_y expected %0d actual %0d", want.y, o_surface_y);
                        mismatches++;
                    end
                    if (o_surface_z !== want.z) begin
                        $error("surface_z expected %0d actual %0d", want.z, o_surface_z);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_action       <= ACT_LOAD;
        i_patch_select <= 1'b0;
        i_point_index  <= '0;
        i_point_x      <= '0;
        i_point_y      <= '0;
        i_point_z      <= '0;
        i_coord_u      <= '0;
        i_coord_v      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_corners();
        test_random(1500);
        test_backpressure();
        quiet = 1;
        test_random(200);
        i_valid <= 1'b0;
        wait (pending_positions.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_positions.size() == 0) begin
            $display("bicubic_bezier_surface_evaluator_top test passed");
        end else begin
            $display("bicubic_bezier_surface_evaluator_top test failed");
        end
        $finish;
    end

endmodule
